// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the divisor search unit.
// Every check is sampled on the rising edge of i_clk and is held off while
// the synchronous reset i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge.
`define RDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// If the condition holds at one edge, the result must hold at the next edge.
`define RDS_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (result)) else $error(msg);

`endif

// File: rtl/core/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Types and constants shared by the divisor search unit: the request codes,
// the match kinds, the sequencer states and the structures that carry one
// search step and one match between the modules.
// ----------------------------------------------------------------------------
package rds_pkg;

    // Width of one truth table.
    localparam int DATA_W = 64;
    // Index width that covers the largest supported store of 64 entries.
    localparam int IDX_W = 6;
    // Width of the index fields of a result word.
    localparam int OUT_IDX_W = 5;

    // Request codes of an input word.
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    // Kind of match reported in a result word.
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SINGLE = 3'd1,
        KIND_AND2   = 3'd2,
        KIND_OR2    = 3'd3,
        KIND_AND3   = 3'd4
    } t_kind;

    // Operation carried by one search step through the read pipeline.
    typedef enum logic [2:0] {
        OP_LOAD_I = 3'd0,
        OP_LOAD_J = 3'd1,
        OP_CMP1   = 3'd2,
        OP_CMP2   = 3'd3,
        OP_CMP3   = 3'd4
    } t_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_SINGLE = 4'd1,
        ST_PAIR_I = 4'd2,
        ST_PAIR_J = 4'd3,
        ST_TRI_I  = 4'd4,
        ST_TRI_J  = 4'd5,
        ST_TRI_K  = 4'd6,
        ST_DRAIN  = 4'd7,
        ST_DONE   = 4'd8
    } t_state;

    // One step issued together with its memory read.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_step;

    // One match: its kind and up to three divisor indices.
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_match;

    localparam t_match MATCH_NONE = '{kind: KIND_NONE, a: '0, b: '0, c: '0};

endpackage

// File: rtl/core/rds_ram.sv
// ----------------------------------------------------------------------------
// rds_ram
// Generic single-port-write, single-port-read memory with a registered read.
// Read data appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module rds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/rds_eval.sv
// ----------------------------------------------------------------------------
// rds_eval
// Evaluation stage of the search pipeline. It takes the step issued in the
// previous cycle together with the word read for it, keeps the first divisor
// and the AND of the first two divisors, and compares against the target.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rds_eval
    import rds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step             i_step,
    input  logic [DATA_W-1:0] i_rd_data,
    input  logic [DATA_W-1:0] i_target,
    output logic              o_hit,
    output t_match            o_cand
);

    t_step             r_s1;
    logic [DATA_W-1:0] r_di;
    logic [DATA_W-1:0] r_dij;
    logic [DATA_W-1:0] and2;
    logic [DATA_W-1:0] or2;
    logic [DATA_W-1:0] and3;

    // Step register aligned with the memory read latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= i_step;
        end
    end

    // Held operands: first divisor and the AND of the first two.
    always_ff @(posedge i_clk) begin
        if (r_s1.valid && (r_s1.op == OP_LOAD_I)) begin
            r_di <= i_rd_data;
        end
        if (r_s1.valid && (r_s1.op == OP_LOAD_J)) begin
            r_dij <= r_di & i_rd_data;
        end
    end

    assign and2 = r_di & i_rd_data;
    assign or2  = r_di | i_rd_data;
    assign and3 = r_dij & i_rd_data;

    // Compare the combination selected by the step against the target.
    always_comb begin
        o_hit  = 1'b0;
        o_cand = MATCH_NONE;
        if (r_s1.valid) begin
            case (r_s1.op)
                OP_CMP1: begin
                    if (i_rd_data == i_target) begin
                        o_hit  = 1'b1;
                        o_cand = '{kind: KIND_SINGLE, a: r_s1.i, b: '0, c: '0};
                    end
                end
                OP_CMP2: begin
                    if (and2 == i_target) begin
                        o_hit  = 1'b1;
                        o_cand = '{kind: KIND_AND2, a: r_s1.i, b: r_s1.j, c: '0};
                    end else if (or2 == i_target) begin
                        o_hit  = 1'b1;
                        o_cand = '{kind: KIND_OR2, a: r_s1.i, b: r_s1.j, c: '0};
                    end
                end
                OP_CMP3: begin
                    if (and3 == i_target) begin
                        o_hit  = 1'b1;
                        o_cand = '{kind: KIND_AND3, a: r_s1.i, b: r_s1.j, c: r_s1.k};
                    end
                end
                default: begin
                    o_hit  = 1'b0;
                    o_cand = MATCH_NONE;
                end
            endcase
        end
    end

    // A pair or triple always names divisors in strictly rising order.
    `RDS_ASSERT(a_eval_pair_order, !(o_hit && (o_cand.kind == KIND_AND2 || o_cand.kind == KIND_OR2)) || (o_cand.a < o_cand.b), "pair match indices out of order")
    `RDS_ASSERT(a_eval_tri_order, !(o_hit && o_cand.kind == KIND_AND3) || ((o_cand.a < o_cand.b) && (o_cand.b < o_cand.c)), "triple match indices out of order")

endmodule

// File: rtl/core/rds_seq.sv
// ----------------------------------------------------------------------------
// rds_seq
// Search sequencer. It walks the stored divisors in the order singles, pairs,
// triples and issues one memory read per cycle with its step. A hit reported
// by the evaluation stage ends the walk, and the pending step is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rds_seq
    import rds_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]    i_count,
    input  logic                                i_hit,
    input  t_match                              i_cand,
    input  logic                                i_out_free,
    output logic                                o_idle,
    output logic                                o_done,
    output t_match                              o_match,
    output t_step                               o_step,
    output logic [$clog2(STORE_DEPTH)-1:0]      o_rd_addr
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_n, n_n;
    t_match        r_match, n_match;

    logic          step_go;
    t_op           step_op;
    logic [CW-1:0] xi, xj, xk;
    logic [CW-1:0] nm1, nm2, nm3;

    assign xi  = CW'(r_i);
    assign xj  = CW'(r_j);
    assign xk  = CW'(r_k);
    assign nm1 = r_n - CW'(1);
    assign nm2 = r_n - CW'(2);
    assign nm3 = r_n - CW'(3);

    // State and index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_n     <= n_n;
        r_match <= n_match;
    end

    // Next state, index walk and read issue.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_n       = r_n;
        n_match   = r_match;
        step_go   = 1'b0;
        step_op   = OP_CMP1;
        o_rd_addr = r_i;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_i     = '0;
                    n_state = (i_count == '0) ? ST_DRAIN : ST_SINGLE;
                end
            end
            ST_SINGLE: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_CMP1;
                    o_rd_addr = r_i;
                    if (xi == nm1) begin
                        n_i     = '0;
                        n_state = (r_n >= CW'(2)) ? ST_PAIR_I : ST_DRAIN;
                    end else begin
                        n_i = r_i + AW'(1);
                    end
                end
            end
            ST_PAIR_I: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_LOAD_I;
                    o_rd_addr = r_i;
                    n_j       = r_i + AW'(1);
                    n_state   = ST_PAIR_J;
                end
            end
            ST_PAIR_J: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_CMP2;
                    o_rd_addr = r_j;
                    if (xj == nm1) begin
                        if (xi == nm2) begin
                            n_i     = '0;
                            n_state = (r_n >= CW'(3)) ? ST_TRI_I : ST_DRAIN;
                        end else begin
                            n_i     = r_i + AW'(1);
                            n_state = ST_PAIR_I;
                        end
                    end else begin
                        n_j = r_j + AW'(1);
                    end
                end
            end
            ST_TRI_I: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_LOAD_I;
                    o_rd_addr = r_i;
                    n_j       = r_i + AW'(1);
                    n_state   = ST_TRI_J;
                end
            end
            ST_TRI_J: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_LOAD_J;
                    o_rd_addr = r_j;
                    n_k       = r_j + AW'(1);
                    n_state   = ST_TRI_K;
                end
            end
            ST_TRI_K: begin
                if (i_hit) begin
                    n_match = i_cand;
                    n_state = ST_DONE;
                end else begin
                    step_go   = 1'b1;
                    step_op   = OP_CMP3;
                    o_rd_addr = r_k;
                    if (xk == nm1) begin
                        if (xj == nm2) begin
                            if (xi == nm3) begin
                                n_state = ST_DRAIN;
                            end else begin
                                n_i     = r_i + AW'(1);
                                n_state = ST_TRI_I;
                            end
                        end else begin
                            n_j     = r_j + AW'(1);
                            n_state = ST_TRI_J;
                        end
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // The last issued step is evaluated in this cycle.
                n_match = i_hit ? i_cand : MATCH_NONE;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_step.valid = step_go;
    assign o_step.op    = step_op;
    assign o_step.i     = IDX_W'(r_i);
    assign o_step.j     = IDX_W'(r_j);
    assign o_step.k     = IDX_W'(r_k);

    assign o_idle  = (r_state == ST_IDLE);
    assign o_done  = (r_state == ST_DONE) && i_out_free;
    assign o_match = r_match;

    // A hit can only come back while a walk is in flight.
    `RDS_ASSERT(a_seq_hit_in_walk, !i_hit || (!o_idle && (r_state != ST_DONE)), "hit outside walk")
    // Every read issued by the walk stays below the loaded divisor count.
    `RDS_ASSERT(a_seq_addr_range, !step_go || (CW'(o_rd_addr) < r_n), "read beyond count")

endmodule

// File: rtl/core/resub_divisor_search_unit.sv
// ----------------------------------------------------------------------------
// resub_divisor_search_unit
// Input channel: each word is a request type and a 64-bit truth table. A load
// word (request type 0) stores a divisor; when the store already holds
// STORE_DEPTH entries the word is dropped and the overflow flag set.
// A search word (request type 1) compares the target against single
// divisors, then pairs i<j by AND then OR, then triples i<j<k by AND, and
// returns the first match as one result word, with the overflow flag. The
// divisor count clears when the search word is taken, the flag when the
// result word is loaded. Loads give no result word. A search with n stored
// divisors is bounded by the single memory read port, which delivers one
// stored word per cycle; a match ends it early. The input is stalled for the
// whole search; loads are taken one per cycle otherwise. The output register
// holds a result word while the receiver stalls; input words are still taken
// then, and a search that finishes waits for the register to empty. Reset
// clears the count, the flag and the control state; stored divisors are not
// cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module resub_divisor_search_unit
    import rds_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [DATA_W-1:0]    i_truth_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [2:0]           o_match_kind,
    output logic [OUT_IDX_W-1:0] o_first_index,
    output logic [OUT_IDX_W-1:0] o_second_index,
    output logic [OUT_IDX_W-1:0] o_third_index,
    output logic                 o_overflow
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic [DATA_W-1:0] r_target;
    logic              r_out_valid;
    logic              r_found;
    logic [2:0]        r_kind;
    logic [OUT_IDX_W-1:0] r_first, r_second, r_third;
    logic              r_out_ovf;

    logic              in_acc;
    logic              is_load;
    logic              start;
    logic              full;
    logic              wr_en;
    logic              out_free;
    logic              seq_idle;
    logic              seq_done;
    t_match            seq_match;
    t_step             step;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              hit;
    t_match            cand;

    // Input handshake: words are taken only while no search runs.
    assign o_in_stall = !seq_idle;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_load    = (t_req'(i_req_type) == REQ_LOAD);
    assign full       = (r_count == CW'(STORE_DEPTH));
    assign wr_en      = in_acc && is_load && !full;
    assign start      = in_acc && !is_load;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Divisor count, overflow flag and target word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (start) begin
                r_count <= '0;
            end
            if (in_acc && is_load && full) begin
                r_ovf <= 1'b1;
            end else if (seq_done) begin
                r_ovf <= 1'b0;
            end
        end
        if (start) begin
            r_target <= i_truth_word;
        end
    end

    // Output register: loaded when a search completes, emptied on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (seq_done) begin
            r_found   <= (seq_match.kind != KIND_NONE);
            r_kind    <= seq_match.kind;
            r_first   <= seq_match.a[OUT_IDX_W-1:0];
            r_second  <= seq_match.b[OUT_IDX_W-1:0];
            r_third   <= seq_match.c[OUT_IDX_W-1:0];
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_kind   = r_kind;
    assign o_first_index  = r_first;
    assign o_second_index = r_second;
    assign o_third_index  = r_third;
    assign o_overflow     = r_out_ovf;

    // Divisor store.
    rds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_truth_word),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Search sequencer.
    rds_seq #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_count    (r_count),
        .i_hit      (hit),
        .i_cand     (cand),
        .i_out_free (out_free),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_match    (seq_match),
        .o_step     (step),
        .o_rd_addr  (rd_addr)
    );

    // Compare stage.
    rds_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rd_data (rd_data),
        .i_target  (r_target),
        .o_hit     (hit),
        .o_cand    (cand)
    );

    // The divisor count never passes the store depth.
    `RDS_ASSERT(a_top_count_bound, r_count <= CW'(STORE_DEPTH), "count beyond store depth")
    // A search clears the count for the next batch of loads.
    `RDS_ASSERT_NEXT(a_top_start_clear, start, r_count == '0, "count not cleared by search")

endmodule

// File: tb/resub_divisor_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Divisor search checker
// Watches the input and result channels of the divisor search unit. It keeps
// its own copy of the divisor store, works out the first matching divisor
// combination for every search word that is taken, and compares each result
// word that leaves the unit with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module resub_divisor_search_checker
    import rds_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_req_type,
    input  logic [DATA_W-1:0]    i_truth_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_found,
    input  logic [2:0]           i_match_kind,
    input  logic [OUT_IDX_W-1:0] i_first_index,
    input  logic [OUT_IDX_W-1:0] i_second_index,
    input  logic [OUT_IDX_W-1:0] i_third_index,
    input  logic                 i_overflow,
    output int                   o_pending,
    output int                   o_errors,
    output int                   o_checked,
    output int                   o_hits
);

    // One predicted result word.
    typedef struct {
        logic                 found;
        t_kind                kind;
        logic [OUT_IDX_W-1:0] first;
        logic [OUT_IDX_W-1:0] second;
        logic [OUT_IDX_W-1:0] third;
        logic                 overflow;
    } t_search_result;

    logic [DATA_W-1:0] table_copy [STORE_DEPTH];
    int                table_fill;
    logic              load_dropped;
    t_search_result    pending_results [$];

    // Builds a result word; indices are cut to the width of the result fields.
    function automatic t_search_result match_word(input t_kind kind, input int a,
                                                  input int b, input int c);
        t_search_result r;
        r.found    = (kind != KIND_NONE);
        r.kind     = kind;
        r.first    = OUT_IDX_W'(a);
        r.second   = OUT_IDX_W'(b);
        r.third    = OUT_IDX_W'(c);
        r.overflow = load_dropped;
        return r;
    endfunction

    // Searches singles, then pairs (AND before OR), then triples by AND.
    function automatic t_search_result first_divisor_match(input logic [DATA_W-1:0] target);
        logic [DATA_W-1:0] pair_and;
        for (int i = 0; i < table_fill; i++)
            if (table_copy[i] == target)
                return match_word(KIND_SINGLE, i, 0, 0);
        for (int i = 0; i < table_fill; i++)
            for (int j = i + 1; j < table_fill; j++) begin
                if ((table_copy[i] & table_copy[j]) == target)
                    return match_word(KIND_AND2, i, j, 0);
                if ((table_copy[i] | table_copy[j]) == target)
                    return match_word(KIND_OR2, i, j, 0);
            end
        for (int i = 0; i < table_fill; i++)
            for (int j = i + 1; j < table_fill; j++) begin
                pair_and = table_copy[i] & table_copy[j];
                for (int k = j + 1; k < table_fill; k++)
                    if ((pair_and & table_copy[k]) == target)
                        return match_word(KIND_AND3, i, j, k);
            end
        return match_word(KIND_NONE, 0, 0, 0);
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            o_errors++;
        end
    endtask

    // Both channels are sampled at the rising edge. The result side is handled
    // first, since a word leaving now always belongs to an earlier search.
    always @(posedge i_clk) begin
        t_search_result want;
        if (!i_rst_n) begin
            table_fill   = 0;
            load_dropped = 1'b0;
            pending_results.delete();
            o_errors     = 0;
            o_checked    = 0;
            o_hits       = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word arrived with no search outstanding");
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", want.found, i_found);
                    check_field("match_kind", want.kind, i_match_kind);
                    check_field("first_index", want.first, i_first_index);
                    check_field("second_index", want.second, i_second_index);
                    check_field("third_index", want.third, i_third_index);
                    check_field("overflow", want.overflow, i_overflow);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_LOAD) begin
                    if (table_fill < STORE_DEPTH) begin
                        table_copy[table_fill] = i_truth_word;
                        table_fill++;
                    end else begin
                        load_dropped = 1'b1;
                    end
                end else begin
                    want = first_divisor_match(i_truth_word);
                    if (want.found)
                        o_hits++;
                    pending_results = {pending_results, want};
                    table_fill   = 0;
                    load_dropped = 1'b0;
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// File: tb/tb_resub_divisor_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Divisor search unit testbench
// Loads sets of divisor truth tables and sends search words whose targets are
// mostly built from single divisors, pairs and triples of the loaded set.
// A short directed part is followed by random sets, most of them small, a few
// filling or overflowing the store, under four idle and stall phases. The
// checker beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_resub_divisor_search_unit;
    import rds_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int PHASE_WORDS = 375;

    localparam logic [DATA_W-1:0] NIBBLE_HI = 64'hF0F0_F0F0_F0F0_F0F0;
    localparam logic [DATA_W-1:0] BYTE_HI   = 64'hFF00_FF00_FF00_FF00;
    localparam logic [DATA_W-1:0] PAIR_HI   = 64'hCCCC_CCCC_CCCC_CCCC;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_LOAD;
    logic [DATA_W-1:0]    truth_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 found;
    logic [2:0]           match_kind;
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic [OUT_IDX_W-1:0] third_index;
    logic                 overflow;

    int pending;
    int error_count;
    int checked_count;
    int hit_count;

    int in_idle_pct  = 0;
    int out_stall_pct = 0;
    int words_sent   = 0;
    int searches_sent = 0;
    int overflow_sets = 0;

    resub_divisor_search_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_truth_word  (truth_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_found       (found),
        .o_match_kind  (match_kind),
        .o_first_index (first_index),
        .o_second_index(second_index),
        .o_third_index (third_index),
        .o_overflow    (overflow)
    );

    resub_divisor_search_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_truth_word  (truth_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_found       (found),
        .i_match_kind  (match_kind),
        .i_first_index (first_index),
        .i_second_index(second_index),
        .i_third_index (third_index),
        .i_overflow    (overflow),
        .o_pending     (pending),
        .o_errors      (error_count),
        .o_checked     (checked_count),
        .o_hits        (hit_count)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("tb_resub_divisor_search_unit: errors");
        $finish;
    end

    // Sends one word: random idle cycles first, then holds it until taken.
    // Returns at a falling edge with valid still high.
    task automatic send_word(input t_req req, input logic [DATA_W-1:0] word);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        truth_word <= word;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        words_sent++;
        if (req == REQ_SEARCH)
            searches_sent++;
    endtask

    // Stops sending until every outstanding result word has arrived.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random truth table, biased to sparse or dense ones now and then.
    function automatic logic [DATA_W-1:0] random_table();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    return a & b;
            2, 3:    return a | b;
            4:       return a & b & {$urandom, $urandom};
            5:       return a | b | {$urandom, $urandom};
            default: return a;
        endcase
    endfunction

    // Loads a set of divisors and searches for a target mostly built from it.
    task automatic run_set(input int set_size);
        logic [DATA_W-1:0] stored [$];
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] target;
        int                count;
        int                pick;
        int                i;
        int                j;
        int                k;
        for (int n = 0; n < set_size; n++) begin
            if (stored.size() > 0 && $urandom_range(0, 19) == 0)
                word = stored[$urandom_range(0, stored.size() - 1)];
            else
                word = random_table();
            if (stored.size() < STORE_DEPTH)
                stored = {stored, word};
            send_word(REQ_LOAD, word);
        end
        count = stored.size();
        pick  = $urandom_range(0, 99);
        if (count == 0 || pick < 15) begin
            target = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
        end else if (pick < 40 || count < 2) begin
            target = stored[$urandom_range(0, count - 1)];
        end else if (pick < 80 || count < 3) begin
            i = $urandom_range(0, count - 2);
            j = $urandom_range(i + 1, count - 1);
            target = (pick < 60) ? (stored[i] & stored[j]) : (stored[i] | stored[j]);
        end else begin
            i = $urandom_range(0, count - 3);
            j = $urandom_range(i + 1, count - 2);
            k = $urandom_range(j + 1, count - 1);
            target = stored[i] & stored[j] & stored[k];
        end
        if (set_size > STORE_DEPTH)
            overflow_sets++;
        send_word(REQ_SEARCH, target);
    endtask

    initial begin
        int set_no;
        int set_size;
        int phase_start;
        set_no = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: empty store, extremes, each kind of match, no match.
        send_word(REQ_SEARCH, '0);
        send_word(REQ_LOAD, '1);
        send_word(REQ_LOAD, '0);
        send_word(REQ_SEARCH, '0);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_SEARCH, NIBBLE_HI);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_LOAD, BYTE_HI);
        send_word(REQ_SEARCH, NIBBLE_HI & BYTE_HI);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_LOAD, BYTE_HI);
        send_word(REQ_SEARCH, NIBBLE_HI | BYTE_HI);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_LOAD, BYTE_HI);
        send_word(REQ_LOAD, PAIR_HI);
        send_word(REQ_SEARCH, NIBBLE_HI & BYTE_HI & PAIR_HI);
        send_word(REQ_LOAD, NIBBLE_HI);
        send_word(REQ_LOAD, BYTE_HI);
        send_word(REQ_LOAD, PAIR_HI);
        send_word(REQ_SEARCH, 64'h1234_5678_9ABC_DEF1);
        wait_for_results();

        // Random sets in four phases: no idling, idle sender, stalling
        // receiver, then both. Every so often a set fills or overflows the
        // store; otherwise sets stay small to keep searches short.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 83; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 83; end
                default: begin in_idle_pct = 34; out_stall_pct = 34; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                set_no++;
                if (set_no % 50 == 7)
                    set_size = $urandom_range(STORE_DEPTH, STORE_DEPTH + 4);
                else if ($urandom_range(0, 19) == 0)
                    set_size = 0;
                else
                    set_size = $urandom_range(1, 10);
                run_set(set_size);
            end
            wait_for_results();
        end

        // Let the unit settle so that any stray result word shows up.
        repeat (100) @(negedge clk);

        $display("Sent %0d words: %0d searches, %0d with a match, %0d after dropped loads;",
                 words_sent, searches_sent, hit_count, overflow_sets);
        $display("%0d result words checked over four idle and stall phases.", checked_count);
        if (error_count == 0) begin
            $display("tb_resub_divisor_search_unit: clean");
        end else begin
            $display("tb_resub_divisor_search_unit: errors");
        end
        $finish;
    end

endmodule
